[hw/rtl/ssr_pkg.sv]
`default_nettype none

package ssr_pkg;

    // Table geometry
    localparam int MAX_IDS = 1024;
    localparam int ID_W    = $clog2(MAX_IDS);
    localparam int CNT_W   = $clog2(MAX_IDS + 1);
    localparam int KIND_W  = 2;
    localparam int TAG_W   = 16;

    // Request codes carried in tuser
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS     = ID_W + KIND_W + TAG_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + ID_W + 1 + ID_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // One row of the per-identifier table
    typedef struct packed {
        logic              present;
        logic [ID_W-1:0]   slot;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One response beat
    typedef struct packed {
        logic [CNT_W-1:0] used_count;
        logic [ID_W-1:0]  moved_ident;
        logic             moved_valid;
        logic [ID_W-1:0]  slot;
        logic             ok;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/ssr_ram.sv]
`default_nettype none

module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/sparse_set_swap_remove_core.sv]
`default_nettype none

// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tdata: ident, kind, tag      tuser: op
// m_axis    out  tdata: ok, slot, moved_valid, moved_ident, used_count
//
// An add, a refused request or a remove that moves nothing finishes in S_LOOKUP;
// a remove that moves the last identifier goes on through S_LAST and S_FIX, as
// the single-port entry table takes its accesses in turn (read own entry, write
// own entry, read moved entry, write moved entry).
// After reset the entry table is swept clear, one row a cycle, through every row;
// s_axis_tready stays low meanwhile. A pending response waits in the output
// register while the next request is taken; work stalls only at its last step.

module sparse_set_swap_remove_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // ident [9:0], kind [11:10], tag [27:12], zero pad
    input  wire logic [ssr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // op [0]
    input  wire logic [0:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // ok [0], slot [10:1], moved_valid [11], moved_ident [21:12],
    // used_count [32:22], zero pad
    output logic [ssr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import ssr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_LAST,
        S_FIX,
        S_HOLD
    } t_state;

    t_state            r_state,     n_state;
    logic [ID_W-1:0]   r_clr_addr,  n_clr_addr;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic              r_op,        n_op;
    logic [ID_W-1:0]   r_id,        n_id;
    logic [KIND_W-1:0] r_kind,      n_kind;
    logic [TAG_W-1:0]  r_tag,       n_tag;
    logic [ID_W-1:0]   r_slot,      n_slot;
    logic [ID_W-1:0]   r_last,      n_last;
    t_result           r_res,       n_res;
    t_result           r_out,       n_out;
    logic              r_out_valid, n_out_valid;

    logic              ent_we;
    logic [ID_W-1:0]   ent_addr;
    t_entry            ent_wdata;
    t_entry            ent_rdata;
    logic              dn_we;
    logic [ID_W-1:0]   dn_addr;
    logic [ID_W-1:0]   dn_wdata;
    logic [ID_W-1:0]   dn_rdata;

    logic              in_beat;
    logic              out_free;
    logic              fin;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  cnt_inc;

    ssr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_IDS)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_addr  (ent_addr),
        .i_wdata (ent_wdata),
        .o_rdata (ent_rdata)
    );

    ssr_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_dense_ram (
        .i_clk   (i_clk),
        .i_we    (dn_we),
        .i_addr  (dn_addr),
        .i_wdata (dn_wdata),
        .o_rdata (dn_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign cnt_dec       = r_count - CNT_W'(1);
    assign cnt_inc       = r_count + CNT_W'(1);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), r_out.used_count,
                            r_out.moved_ident, r_out.moved_valid, r_out.slot, r_out.ok};

    // Sequence table accesses and build the response
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_op        = r_op;
        n_id        = r_id;
        n_kind      = r_kind;
        n_tag       = r_tag;
        n_slot      = r_slot;
        n_last      = r_last;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ent_we      = 1'b0;
        ent_addr    = r_id;
        ent_wdata   = ent_rdata;
        dn_we       = 1'b0;
        dn_addr     = r_slot;
        dn_wdata    = r_last;
        fin         = 1'b0;

        // Drop the response once its beat is taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ent_we     = 1'b1;
                ent_addr   = r_clr_addr;
                ent_wdata  = '0;
                n_clr_addr = r_clr_addr + ID_W'(1);
                if (r_clr_addr == ID_W'(MAX_IDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ent_addr = s_axis_tdata[ID_W-1:0];
                if (in_beat) begin
                    n_op    = s_axis_tuser[0];
                    n_id    = s_axis_tdata[ID_W-1:0];
                    n_kind  = s_axis_tdata[ID_W +: KIND_W];
                    n_tag   = s_axis_tdata[ID_W + KIND_W +: TAG_W];
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_res            = '0;
                n_res.used_count = r_count;
                if (r_op == OP_ADD) begin
                    fin = 1'b1;
                    if (!ent_rdata.present && r_count < CNT_W'(MAX_IDS)) begin
                        // Append to the dense list
                        ent_we            = 1'b1;
                        ent_wdata.present = 1'b1;
                        ent_wdata.slot    = r_count[ID_W-1:0];
                        ent_wdata.kind    = r_kind;
                        ent_wdata.tag     = r_tag;
                        dn_we             = 1'b1;
                        dn_addr           = r_count[ID_W-1:0];
                        dn_wdata          = r_id;
                        n_count           = cnt_inc;
                        n_res.ok          = 1'b1;
                        n_res.slot        = r_count[ID_W-1:0];
                        n_res.used_count  = cnt_inc;
                    end
                end else if (ent_rdata.present && r_count != '0) begin
                    // Mark absent, then fetch the last dense identifier if needed
                    ent_we            = 1'b1;
                    ent_wdata.present = 1'b0;
                    n_count           = cnt_dec;
                    n_slot            = ent_rdata.slot;
                    if ({1'b0, ent_rdata.slot} < cnt_dec) begin
                        dn_addr = cnt_dec[ID_W-1:0];
                        n_state = S_LAST;
                    end else begin
                        n_res.ok         = 1'b1;
                        n_res.slot       = ent_rdata.slot;
                        n_res.used_count = cnt_dec;
                        fin              = 1'b1;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            S_LAST: begin
                // Move the last identifier into the vacated slot
                n_last   = dn_rdata;
                dn_we    = 1'b1;
                dn_addr  = r_slot;
                dn_wdata = dn_rdata;
                ent_addr = dn_rdata;
                n_state  = S_FIX;
            end
            S_FIX: begin
                // Point the moved identifier at its new slot
                ent_we            = 1'b1;
                ent_addr          = r_last;
                ent_wdata.slot    = r_slot;
                n_res.ok          = 1'b1;
                n_res.slot        = r_slot;
                n_res.moved_valid = 1'b1;
                n_res.moved_ident = r_last;
                n_res.used_count  = r_count;
                fin               = 1'b1;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the response to the output register, or hold it
        if (fin) begin
            if (out_free) begin
                n_out       = n_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op   <= n_op;
        r_id   <= n_id;
        r_kind <= n_kind;
        r_tag  <= n_tag;
        r_slot <= n_slot;
        r_last <= n_last;
        r_res  <= n_res;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_IDS))
        else $error("present count beyond table size");

    a_beat_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_LOOKUP))
        else $error("accepted request did not start a lookup");

    a_count_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(r_state) == S_LOOKUP)
        else $error("count changed outside lookup");

    a_moved_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> ent_rdata.present)
        else $error("moved identifier not present");
`endif

endmodule

`default_nettype wire
